[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/spq_pkg.sv]
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b1;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] run_time;
        logic [7:0]  tag;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[rtl/spq_cell.sv]
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // keep: this entry stays ahead of the new one
    assign keep  = occupied && (entry_reg.prio <= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/stable_priority_queue.sv]
// Stable sorted priority queue built as a row of QUEUE_DEPTH entry cells.
// The result waits in a pending register, then loads into the output register once the output is free.
// Throughput: one item per cycle while in_stall is low; all cells update together from their neighbors.
// Reset (async, active low): count zero, output empty, floor 0, ceiling 255.
// Entry cells are not reset; only the first count cells are ever shown.
module stable_priority_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic [7:0]                      priority_req,
    input  logic [15:0]                     run_time,
    input  logic [7:0]                      process_tag,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [4:0]                      occupancy,
    output logic [7:0]                      head_priority,
    output logic [15:0]                     head_run_time,
    output logic [7:0]                      head_tag,
    output logic [7:0]                      tail_priority,
    output logic [15:0]                     tail_run_time,
    output logic [7:0]                      tail_tag
);
    import spq_pkg::*;

    logic [7:0]       floor_reg;
    logic [7:0]       ceiling_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    status_t          pend_status_reg;
    status_t          step_status;
    logic             step_ins;
    logic             step_rem;
    logic             accept;
    logic             out_load;
    cell_ctrl_t       ctrl;
    entry_t           cell_entry [QUEUE_DEPTH];
    logic             keep_vec   [QUEUE_DEPTH];
    logic [IDX_W-1:0] tail_idx;
    logic             empty;
    entry_t           head_sel;
    entry_t           tail_sel;

    logic             out_valid_reg;
    status_t          status_reg;
    logic [4:0]       occupancy_reg;
    entry_t           head_reg;
    entry_t           tail_reg;

    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = pend_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        step_status = ST_OK;
        step_ins    = 1'b0;
        step_rem    = 1'b0;
        count_next  = count_reg;
        unique case (cmd_t'(command))
            CMD_INSERT:
            begin
                if ((priority_req < floor_reg) || (priority_req > ceiling_reg))
                begin
                    step_status = ST_RANGE;
                end
                else if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    step_status = ST_FULL;
                end
                else
                begin
                    step_ins   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    step_status = ST_EMPTY;
                end
                else
                begin
                    step_rem   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_READ:
            begin
                if (count_reg == '0)
                begin
                    step_status = ST_EMPTY;
                end
            end
            default:
            begin
                step_status = ST_OK;
            end
        endcase
    end

    assign ctrl.ins                = accept && step_ins;
    assign ctrl.rem                = accept && step_rem;
    assign ctrl.new_entry.prio     = priority_req;
    assign ctrl.new_entry.run_time = run_time;
    assign ctrl.new_entry.tag      = process_tag;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_keep;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = ctrl.new_entry;
        end
        else
        begin : g_mid
            assign left_keep  = keep_vec[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (keep_vec[i])
        );
    end

    assign empty    = (count_reg == '0);
    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));
    assign head_sel = empty ? '0 : cell_entry[0];
    assign tail_sel = empty ? '0 : cell_entry[tail_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg     <= 8'd0;
            ceiling_reg   <= 8'd255;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FLOOR:   floor_reg   <= cfg_data;
                    CFG_CEILING: ceiling_reg <= cfg_data;
                    default:     floor_reg   <= floor_reg;
                endcase
            end
            if (accept)
            begin
                count_reg <= count_next;
                pend_reg  <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= pend_reg;
            end
        end
    end

    // hold result payload; load from the settled cells when the pending result can go out
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= step_status;
        end
        if (out_load && pend_reg)
        begin
            status_reg    <= pend_status_reg;
            occupancy_reg <= 5'(count_reg);
            head_reg      <= head_sel;
            tail_reg      <= tail_sel;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign occupancy     = occupancy_reg;
    assign head_priority = head_reg.prio;
    assign head_run_time = head_reg.run_time;
    assign head_tag      = head_reg.tag;
    assign tail_priority = tail_reg.prio;
    assign tail_run_time = tail_reg.run_time;
    assign tail_tag      = tail_reg.tag;

endmodule

[rtl/spq_checker.sv]
`include "assert_macros.svh"

module spq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [spq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [spq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [1:0]                      command,
    input logic [7:0]                      priority_req,
    input logic [15:0]                     run_time,
    input logic [7:0]                      process_tag,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      status,
    input logic [4:0]                      occupancy,
    input logic [7:0]                      head_priority,
    input logic [15:0]                     head_run_time,
    input logic [7:0]                      head_tag,
    input logic [7:0]                      tail_priority,
    input logic [15:0]                     tail_run_time,
    input logic [7:0]                      tail_tag
);
    import spq_pkg::*;

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(occupancy) && $stable(head_tag) && $stable(tail_tag))
    `ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall)
    `ASSERT_IMPL(a_empty_zero_count, out_valid && (status == ST_EMPTY), occupancy == 5'd0)
    `ASSERT_IMPL(a_empty_zero_fields, out_valid && (occupancy == 5'd0) && (status == ST_EMPTY), (head_priority == 8'd0) && (head_run_time == 16'd0) && (tail_tag == 8'd0))
    `ASSERT_IMPL(a_sorted_ends, out_valid && (occupancy != 5'd0), head_priority <= tail_priority)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
